### rtl/core/lsts_pkg.sv
// shared types, codes and constants for the lcd scanline timing sequencer
package lsts_pkg;

  localparam int LINES_PER_FRAME_DEF = 154;
  localparam int VISIBLE_LINES_DEF   = 144;
  localparam int LINE_CYCLES_DEF     = 456;

  localparam int OAM_CYCLES  = 80;
  localparam int XFER_CYCLES = 169;
  localparam int VBL_DELAY   = 32;

  localparam int RUN_W   = 9;
  localparam int LINE_W  = 8;
  localparam int ADDR_W  = 3;
  localparam int DATA_W  = 32;

  // item codes on the input channel
  typedef enum logic [1:0] {
    ITEM_TICK = 2'd0,
    ITEM_LCDC = 2'd1,
    ITEM_STAT = 2'd2,
    ITEM_LYC  = 2'd3
  } item_t;

  // stat mode codes
  typedef enum logic [1:0] {
    MODE_HBLANK = 2'd0,
    MODE_VBLANK = 2'd1,
    MODE_OAM    = 2'd2,
    MODE_XFER   = 2'd3
  } stat_mode_t;

  // configuration register indexes
  typedef enum logic [0:0] {
    REG_FRAME_SKIP = 1'b0
  } reg_idx_t;

  typedef struct packed {
    logic [LINE_W-1:0] line_count;
    logic [1:0]        phase;
    stat_mode_t        cur_mode;
    logic [3:0]        stat_enables;
    logic              coincide_flag;
    logic [LINE_W-1:0] compare_line;
    logic              display_enabled;
    logic              stat_line_level;
    logic [7:0]        frames_since_shown;
    logic [7:0]        skip_in_effect;
    logic [7:0]        off_line_count;
  } lsts_state_t;

  typedef struct packed {
    logic [LINE_W-1:0] ly;
    stat_mode_t        stat_mode;
    logic              coincidence;
    logic              stat_irq;
    logic              vblank_irq;
    logic [RUN_W-1:0]  run_cycles;
    logic              frame_start;
    logic              frame_shown;
    logic              render_line;
    logic              blank_frame;
    logic              lcd_on;
  } lsts_result_t;

  // level of the combined stat interrupt line
  function automatic logic stat_level(input stat_mode_t m, input logic coinc,
                                      input logic [3:0] en);
    stat_level = (en[0] && m == MODE_HBLANK) || (en[1] && m == MODE_VBLANK) ||
                 (en[2] && m == MODE_OAM) || (en[3] && coinc);
  endfunction

endpackage

### rtl/core/lsts_step.sv
// next-state and result logic for one timing tick or register write
module lsts_step #(
  parameter int LINES_PER_FRAME = lsts_pkg::LINES_PER_FRAME_DEF,
  parameter int VISIBLE_LINES   = lsts_pkg::VISIBLE_LINES_DEF,
  parameter int LINE_CYCLES     = lsts_pkg::LINE_CYCLES_DEF
) (
  input  lsts_pkg::lsts_state_t  st,
  input  lsts_pkg::item_t        item,
  input  logic [7:0]             value,
  input  logic [7:0]             frame_skip,
  output lsts_pkg::lsts_state_t  nxt,
  output lsts_pkg::lsts_result_t res
);
  import lsts_pkg::*;

  localparam logic [LINE_W-1:0] VIS_L  = LINE_W'(VISIBLE_LINES);
  localparam logic [LINE_W-1:0] LAST_L = LINE_W'(LINES_PER_FRAME - 1);
  localparam logic [LINE_W:0]   LPF_L  = (LINE_W+1)'(LINES_PER_FRAME);
  localparam logic [9:0] RUN_FULL_L = 10'(LINE_CYCLES);
  localparam logic [9:0] RUN_HBL_L  = 10'(LINE_CYCLES - OAM_CYCLES - XFER_CYCLES);
  localparam logic [9:0] RUN_VBL_L  = 10'(LINE_CYCLES - VBL_DELAY);
  localparam logic [9:0] RUN_LAST_L = 10'(LINE_CYCLES - OAM_CYCLES);
  localparam logic [RUN_W-1:0] RUN_FULL = RUN_FULL_L[RUN_W-1:0];
  localparam logic [RUN_W-1:0] RUN_HBL  = RUN_HBL_L[RUN_W-1:0];
  localparam logic [RUN_W-1:0] RUN_VBL  = RUN_VBL_L[RUN_W-1:0];
  localparam logic [RUN_W-1:0] RUN_LAST = RUN_LAST_L[RUN_W-1:0];
  localparam logic [RUN_W-1:0] RUN_OAM  = RUN_W'(OAM_CYCLES);
  localparam logic [RUN_W-1:0] RUN_XFER = RUN_W'(XFER_CYCLES);
  localparam logic [RUN_W-1:0] RUN_DLY  = RUN_W'(VBL_DELAY);

  function automatic logic [1:0] points_of(input logic [LINE_W-1:0] lc);
    if (lc < VIS_L)        points_of = 2'd3;
    else if (lc == VIS_L)  points_of = 2'd2;
    else if (lc == LAST_L) points_of = 2'd2;
    else                   points_of = 2'd1;
  endfunction

  logic [LINE_W:0]   lc_inc;
  logic [LINE_W-1:0] lc_new;
  logic              line_start;
  logic              coinc_new;
  stat_mode_t        mode_new;
  logic              lvl_a;
  logic              lvl_b;
  logic              lvl_xfer;
  logic              lvl_hbl;
  logic              fb_hit;
  logic [7:0]        fss_adv;
  logic [7:0]        off_inc;
  logic              off_wrap;

  assign lc_inc     = {1'b0, st.line_count} + (LINE_W+1)'(1);
  assign lc_new     = (lc_inc >= LPF_L) ? '0 : lc_inc[LINE_W-1:0];
  assign line_start = (st.phase == 2'd0) || (st.phase >= points_of(st.line_count));
  assign coinc_new  = (st.compare_line == lc_new);
  assign mode_new   = (lc_new >= VIS_L) ? MODE_VBLANK : MODE_OAM;
  assign lvl_a      = stat_level(MODE_HBLANK, coinc_new, st.stat_enables);
  assign lvl_b      = stat_level(mode_new, coinc_new, st.stat_enables);
  assign lvl_xfer   = stat_level(MODE_XFER, st.coincide_flag, st.stat_enables);
  assign lvl_hbl    = stat_level(MODE_HBLANK, st.coincide_flag, st.stat_enables);
  // frame boundary: present when enough frames were skipped
  assign fb_hit     = (st.frames_since_shown >= st.skip_in_effect);
  assign fss_adv    = fb_hit ? 8'd0 : st.frames_since_shown + 8'd1;
  assign off_inc    = st.off_line_count + 8'd1;
  assign off_wrap   = ({1'b0, off_inc} >= LPF_L);

  always_comb begin
    nxt = st;
    res = '0;
    case (item)
      ITEM_LCDC: nxt.display_enabled = value[7];
      ITEM_STAT: nxt.stat_enables = value[6:3];
      ITEM_LYC:  nxt.compare_line = value;
      default: begin
        if (!st.display_enabled) begin
          nxt.line_count      = '0;
          nxt.phase           = 2'd0;
          nxt.cur_mode        = MODE_HBLANK;
          nxt.stat_line_level = 1'b0;
          nxt.off_line_count  = off_wrap ? 8'd0 : off_inc;
          if (off_wrap) begin
            res.blank_frame        = 1'b1;
            res.frame_start        = 1'b1;
            res.frame_shown        = fb_hit;
            nxt.frames_since_shown = fss_adv;
          end
          res.run_cycles = RUN_FULL;
          res.ly         = '0;
        end else if (line_start) begin
          nxt.line_count      = lc_new;
          nxt.coincide_flag   = coinc_new;
          nxt.cur_mode        = mode_new;
          nxt.stat_line_level = lvl_b;
          res.stat_irq        = (lvl_a && !st.stat_line_level) || (lvl_b && !lvl_a);
          if (lc_new == '0) begin
            res.frame_start        = 1'b1;
            res.frame_shown        = fb_hit;
            nxt.frames_since_shown = fss_adv;
            nxt.skip_in_effect     = frame_skip;
          end
          if (lc_new < VIS_L)        res.run_cycles = RUN_OAM;
          else if (lc_new == VIS_L)  res.run_cycles = RUN_DLY;
          else if (lc_new == LAST_L) res.run_cycles = RUN_OAM;
          else                       res.run_cycles = RUN_FULL;
          nxt.phase = (points_of(lc_new) > 2'd1) ? 2'd1 : 2'd0;
          res.ly    = lc_new;
        end else if (st.line_count < VIS_L) begin
          if (st.phase == 2'd1) begin
            nxt.cur_mode        = MODE_XFER;
            nxt.stat_line_level = lvl_xfer;
            res.stat_irq        = lvl_xfer && !st.stat_line_level;
            res.run_cycles      = RUN_XFER;
            nxt.phase           = 2'd2;
          end else begin
            nxt.cur_mode        = MODE_HBLANK;
            res.render_line     = fb_hit;
            nxt.stat_line_level = lvl_hbl;
            res.stat_irq        = lvl_hbl && !st.stat_line_level;
            res.run_cycles      = RUN_HBL;
            nxt.phase           = 2'd0;
          end
          res.ly = st.line_count;
        end else if (st.line_count == VIS_L) begin
          res.vblank_irq = 1'b1;
          res.run_cycles = RUN_VBL;
          nxt.phase      = 2'd0;
          res.ly         = st.line_count;
        end else begin
          res.run_cycles = RUN_LAST;
          nxt.phase      = 2'd0;
          res.ly         = '0;
        end
      end
    endcase
    // writes report the line as software sees it after the update
    if (item != ITEM_TICK) begin
      if (nxt.display_enabled && nxt.cur_mode == MODE_VBLANK && nxt.phase == 2'd0 &&
          nxt.line_count == LAST_L && LAST_L != VIS_L)
        res.ly = '0;
      else
        res.ly = nxt.line_count;
    end
    res.stat_mode   = nxt.cur_mode;
    res.coincidence = nxt.coincide_flag;
    res.lcd_on      = nxt.display_enabled;
  end

endmodule

### rtl/core/lcd_scanline_timing_sequencer_core.sv
// top level of the lcd scanline timing sequencer: beat registers, state and config port
// a beat moves from the input beat register to the result beat register on out_
// throughput: one beat per cycle; while a result waits under out_stall the input
//   register takes one more beat, then in_stall holds the sender
// the single step of next-state logic lies between those registers
// reset (rst_n low, synchronous): line 153, phase 0, lcd on, all flags and counters
//   cleared, frame_skip 0, both beat registers empty
module lcd_scanline_timing_sequencer_core #(
  parameter int LINES_PER_FRAME = lsts_pkg::LINES_PER_FRAME_DEF,
  parameter int VISIBLE_LINES   = lsts_pkg::VISIBLE_LINES_DEF,
  parameter int LINE_CYCLES     = lsts_pkg::LINE_CYCLES_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  // input channel
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [1:0]                  in_mode,
  input  logic [7:0]                  in_value,
  // result channel
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [7:0]                  out_ly,
  output logic [1:0]                  out_stat_mode,
  output logic                        out_coincidence,
  output logic                        out_stat_irq,
  output logic                        out_vblank_irq,
  output logic [8:0]                  out_run_cycles,
  output logic                        out_frame_start,
  output logic                        out_frame_shown,
  output logic                        out_render_line,
  output logic                        out_blank_frame,
  output logic                        out_lcd_on,
  // configuration port
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [lsts_pkg::ADDR_W-1:0] paddr,
  input  logic [lsts_pkg::DATA_W-1:0] pwdata,
  output logic [lsts_pkg::DATA_W-1:0] prdata,
  output logic                        pready
);
  import lsts_pkg::*;

  // configuration register
  logic [7:0] frame_skip_r;
  logic       cfg_wr;
  reg_idx_t   cfg_idx;

  // input beat register
  logic       in_vld_r;
  item_t      in_item_r;
  logic [7:0] in_value_r;

  // result beat register
  logic         out_vld_r;
  lsts_result_t out_res_r;

  // timing state
  lsts_state_t  st_r;
  lsts_state_t  st_nxt;
  lsts_result_t res_nxt;

  logic advance;
  logic in_take;

  // register index is the word address; byte lanes within a word are ignored
  assign cfg_idx = reg_idx_t'(paddr[2]);
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign pready  = 1'b1;

  always_comb begin
    prdata = '0;
    case (cfg_idx)
      REG_FRAME_SKIP: prdata = DATA_W'(frame_skip_r);
      default:        prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_skip_r <= '0;
    end else if (cfg_wr && cfg_idx == REG_FRAME_SKIP) begin
      frame_skip_r <= pwdata[7:0];
    end
  end

  // the held input beat moves on when the result register is empty or draining
  assign advance  = in_vld_r && (!out_vld_r || !out_stall);
  assign in_stall = in_vld_r && out_vld_r && out_stall;
  assign in_take  = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_take) begin
      in_vld_r <= 1'b1;
    end else if (advance) begin
      in_vld_r <= 1'b0;
    end
  end

  // payload holds no reset
  always_ff @(posedge clk) begin
    if (in_take) begin
      in_item_r  <= item_t'(in_mode);
      in_value_r <= in_value;
    end
  end

  lsts_step #(
    .LINES_PER_FRAME (LINES_PER_FRAME),
    .VISIBLE_LINES   (VISIBLE_LINES),
    .LINE_CYCLES     (LINE_CYCLES)
  ) u_step (
    .st         (st_r),
    .item       (in_item_r),
    .value      (in_value_r),
    .frame_skip (frame_skip_r),
    .nxt        (st_nxt),
    .res        (res_nxt)
  );

  // timing state commits together with the result beat
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r.line_count         <= LINE_W'(153);
      st_r.phase              <= 2'd0;
      st_r.cur_mode           <= MODE_HBLANK;
      st_r.stat_enables       <= '0;
      st_r.coincide_flag      <= 1'b0;
      st_r.compare_line       <= '0;
      st_r.display_enabled    <= 1'b1;
      st_r.stat_line_level    <= 1'b0;
      st_r.frames_since_shown <= '0;
      st_r.skip_in_effect     <= '0;
      st_r.off_line_count     <= '0;
    end else if (advance) begin
      st_r <= st_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (advance) begin
      out_vld_r <= 1'b1;
    end else if (!out_stall) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_res_r <= res_nxt;
    end
  end

  assign out_valid       = out_vld_r;
  assign out_ly          = out_res_r.ly;
  assign out_stat_mode   = out_res_r.stat_mode;
  assign out_coincidence = out_res_r.coincidence;
  assign out_stat_irq    = out_res_r.stat_irq;
  assign out_vblank_irq  = out_res_r.vblank_irq;
  assign out_run_cycles  = out_res_r.run_cycles;
  assign out_frame_start = out_res_r.frame_start;
  assign out_frame_shown = out_res_r.frame_shown;
  assign out_render_line = out_res_r.render_line;
  assign out_blank_frame = out_res_r.blank_frame;
  assign out_lcd_on      = out_res_r.lcd_on;

  // vblank request only at the second point of the first blank line
  a_vblank_line : assert property (@(posedge clk) disable iff (!rst_n)
    (out_vld_r && out_res_r.vblank_irq) |->
      (out_res_r.ly == LINE_W'(VISIBLE_LINES) && out_res_r.stat_mode == MODE_VBLANK))
    else $error("vblank request off its line");

  // a blank frame is a frame start with the lcd off
  a_blank_frame : assert property (@(posedge clk) disable iff (!rst_n)
    (out_vld_r && out_res_r.blank_frame) |->
      (out_res_r.frame_start && !out_res_r.lcd_on))
    else $error("blank frame without frame start or with lcd on");

  // only a frame start can present a frame
  a_frame_shown : assert property (@(posedge clk) disable iff (!rst_n)
    (out_vld_r && out_res_r.frame_shown) |-> out_res_r.frame_start)
    else $error("frame shown without frame start");

  // a drawn line is reported in hblank
  a_render_hblank : assert property (@(posedge clk) disable iff (!rst_n)
    (out_vld_r && out_res_r.render_line) |-> (out_res_r.stat_mode == MODE_HBLANK))
    else $error("render outside hblank");

  // the state moves only when a beat is taken into the result register
  a_state_hold : assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) && !$past(advance) |-> $stable(st_r))
    else $error("timing state changed without a beat");

endmodule

### tb/tb_top.sv
// self-checking testbench for the lcd scanline timing sequencer core
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import lsts_pkg::*;

  localparam int CLK_PERIOD = 10;
  localparam int RAND_BEATS = 1400;
  localparam int N_DIR      = 24;
  localparam int LPF        = LINES_PER_FRAME_DEF;
  localparam int VIS        = VISIBLE_LINES_DEF;
  localparam int LINE_CYC   = LINE_CYCLES_DEF;
  localparam int TAIL_WAIT  = 4;  // result register plus margin

  localparam logic [RUN_W-1:0] RUN_OAM    = RUN_W'(OAM_CYCLES);
  localparam logic [RUN_W-1:0] RUN_XFER   = RUN_W'(XFER_CYCLES);
  localparam logic [RUN_W-1:0] RUN_VDELAY = RUN_W'(VBL_DELAY);
  localparam logic [RUN_W-1:0] RUN_LINE   = RUN_W'(LINE_CYC);
  localparam logic [RUN_W-1:0] RUN_HBL    = RUN_W'(LINE_CYC - OAM_CYCLES - XFER_CYCLES);
  localparam logic [RUN_W-1:0] RUN_VREST  = RUN_W'(LINE_CYC - VBL_DELAY);
  localparam logic [RUN_W-1:0] RUN_LAST   = RUN_W'(LINE_CYC - OAM_CYCLES);
  localparam lsts_result_t     NO_PT      = '0;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_valid = 1'b0;
  logic              in_stall;
  logic [1:0]        in_mode = '0;
  logic [7:0]        in_value = '0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  logic [7:0]        out_ly;
  logic [1:0]        out_stat_mode;
  logic              out_coincidence;
  logic              out_stat_irq;
  logic              out_vblank_irq;
  logic [8:0]        out_run_cycles;
  logic              out_frame_start;
  logic              out_frame_shown;
  logic              out_render_line;
  logic              out_blank_frame;
  logic              out_lcd_on;
  logic              psel = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite = 1'b0;
  logic [ADDR_W-1:0] paddr = '0;
  logic [DATA_W-1:0] pwdata = '0;
  logic [DATA_W-1:0] prdata;
  logic              pready;

  always #(CLK_PERIOD / 2) clk = ~clk;

  lcd_scanline_timing_sequencer_core uut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_mode        (in_mode),
    .in_value       (in_value),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_ly         (out_ly),
    .out_stat_mode  (out_stat_mode),
    .out_coincidence(out_coincidence),
    .out_stat_irq   (out_stat_irq),
    .out_vblank_irq (out_vblank_irq),
    .out_run_cycles (out_run_cycles),
    .out_frame_start(out_frame_start),
    .out_frame_shown(out_frame_shown),
    .out_render_line(out_render_line),
    .out_blank_frame(out_blank_frame),
    .out_lcd_on     (out_lcd_on),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready)
  );

  // ---------------------------------------------------------------------------
  // timing model: our own copy of the sequencer state, starts at reset values
  // ---------------------------------------------------------------------------
  int unsigned line_no     = 153;   // line counter, 0 .. LPF-1
  int unsigned next_point  = 0;     // index of the next timing point, 0 = new line
  stat_mode_t  cur_mode_q  = MODE_HBLANK;
  logic [3:0]  stat_en     = '0;    // hblank, vblank, oam, compare
  logic        lyc_match   = 1'b0;
  logic [7:0]  lyc_val     = '0;
  logic        lcd_en      = 1'b1;
  logic        stat_line   = 1'b0;  // level of the or'ed stat sources
  logic [7:0]  skipped_cnt = '0;    // frames since the last presented one
  logic [7:0]  skip_live   = '0;    // skip count latched at frame start
  logic [7:0]  off_lines   = '0;    // lines counted with the lcd off
  logic [7:0]  skip_cfg    = '0;    // frame_skip register

  // stat line: only a rising level asks for an interrupt
  function automatic logic stat_rise();
    logic lvl;
    logic rise;
    if (!lcd_en) begin
      stat_line = 1'b0;
      return 1'b0;
    end
    lvl = (stat_en[0] && cur_mode_q == MODE_HBLANK) ||
          (stat_en[1] && cur_mode_q == MODE_VBLANK) ||
          (stat_en[2] && cur_mode_q == MODE_OAM) ||
          (stat_en[3] && lyc_match);
    rise = lvl && !stat_line;
    stat_line = lvl;
    return rise;
  endfunction

  // frame-skip decision at each frame boundary
  function automatic logic frame_presented();
    if (skipped_cnt >= skip_live) begin
      skipped_cnt = '0;
      return 1'b1;
    end
    skipped_cnt = skipped_cnt + 8'd1;
    return 1'b0;
  endfunction

  function automatic int unsigned points_in(int unsigned ln);
    if (ln < VIS) return 3;
    if (ln == VIS) return 2;
    if (ln == LPF - 1) return 2;
    return 1;
  endfunction

  // the last line reads as 0 once its second point has passed
  function automatic logic [7:0] visible_ly();
    if (lcd_en && cur_mode_q == MODE_VBLANK && next_point == 0 &&
        line_no == LPF - 1 && line_no != VIS)
      return 8'd0;
    return 8'(line_no);
  endfunction

  // advances the model by one beat and returns the timing point it reports
  function automatic lsts_result_t next_timing_point(item_t kind, logic [7:0] val);
    lsts_result_t r;
    int unsigned ln, pts;
    r = '0;
    case (kind)
      ITEM_LCDC: begin
        lcd_en = val[7];
        r.ly = visible_ly();
      end
      ITEM_STAT: begin
        stat_en = val[6:3];
        r.ly = visible_ly();
      end
      ITEM_LYC: begin
        lyc_val = val;
        r.ly = visible_ly();
      end
      default: begin
        if (!lcd_en) begin
          // lcd off: blank lines, compare flag frozen
          line_no = 0;
          next_point = 0;
          cur_mode_q = MODE_HBLANK;
          stat_line = 1'b0;
          off_lines = off_lines + 8'd1;
          if (off_lines >= LPF) begin
            r.blank_frame = 1'b1;
            r.frame_start = 1'b1;
            r.frame_shown = frame_presented();
            off_lines = '0;
          end
          r.run_cycles = RUN_LINE;
          r.ly = 8'd0;
        end else begin
          ln = line_no;
          pts = points_in(ln);
          if (next_point == 0 || next_point >= pts) begin
            // line start: evaluate stat with mode 0, then with the line's mode
            ln = ln + 1;
            if (ln >= LPF) ln = 0;
            line_no = ln;
            pts = points_in(ln);
            cur_mode_q = MODE_HBLANK;
            lyc_match = (lyc_val == 8'(ln));
            if (stat_rise()) r.stat_irq = 1'b1;
            if (ln == 0) begin
              r.frame_start = 1'b1;
              r.frame_shown = frame_presented();
              skip_live = skip_cfg;
            end
            cur_mode_q = (ln >= VIS) ? MODE_VBLANK : MODE_OAM;
            if (stat_rise()) r.stat_irq = 1'b1;
            if (ln < VIS) r.run_cycles = RUN_OAM;
            else if (ln == VIS) r.run_cycles = RUN_VDELAY;
            else if (pts == 2) r.run_cycles = RUN_OAM;
            else r.run_cycles = RUN_LINE;
            next_point = (pts > 1) ? 1 : 0;
            r.ly = 8'(ln);
          end else if (ln < VIS) begin
            if (next_point == 1) begin
              cur_mode_q = MODE_XFER;
              if (stat_rise()) r.stat_irq = 1'b1;
              r.run_cycles = RUN_XFER;
              next_point = 2;
            end else begin
              cur_mode_q = MODE_HBLANK;
              r.render_line = (skipped_cnt >= skip_live);
              if (stat_rise()) r.stat_irq = 1'b1;
              r.run_cycles = RUN_HBL;
              next_point = 0;
            end
            r.ly = 8'(ln);
          end else if (ln == VIS) begin
            // vblank request after the short first point
            r.vblank_irq = 1'b1;
            r.run_cycles = RUN_VREST;
            next_point = 0;
            r.ly = 8'(ln);
          end else begin
            r.run_cycles = RUN_LAST;
            next_point = 0;
            r.ly = 8'd0;
          end
        end
      end
    endcase
    r.stat_mode = cur_mode_q;
    r.coincidence = lyc_match;
    r.lcd_on = lcd_en;
    return r;
  endfunction

  function automatic lsts_result_t typed_pt(logic [7:0] ly, stat_mode_t m, logic coin,
                                            logic sirq, logic virq, logic [8:0] run,
                                            logic fs, logic fsh, logic rl, logic bf,
                                            logic on);
    lsts_result_t r;
    r.ly = ly;
    r.stat_mode = m;
    r.coincidence = coin;
    r.stat_irq = sirq;
    r.vblank_irq = virq;
    r.run_cycles = run;
    r.frame_start = fs;
    r.frame_shown = fsh;
    r.render_line = rl;
    r.blank_frame = bf;
    r.lcd_on = on;
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // sender: bursts of beats with random gaps, expectations queued on accept
  // ---------------------------------------------------------------------------
  lsts_result_t pending_points[$];
  int unsigned  burst_left = 0;
  int unsigned  beat_count = 0, tick_count = 0, write_count = 0, skip_writes = 0;
  int unsigned  frame_count = 0, shown_count = 0, blank_count = 0;
  int unsigned  stat_irq_count = 0, vblank_count = 0;
  int unsigned  err_count = 0;

  task automatic send_beat(item_t kind, logic [7:0] val, bit typed, lsts_result_t typed_want);
    lsts_result_t pt;
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_valid <= 1'b1;
    in_mode  <= kind;
    in_value <= val;
    do @(posedge clk); while (in_stall);
    pt = next_timing_point(kind, val);
    if (typed) pt = typed_want;
    pending_points.push_back(pt);
    beat_count++;
    if (kind == ITEM_TICK) tick_count++;
    else write_count++;
    frame_count += int'(pt.frame_start);
    shown_count += int'(pt.frame_shown);
    blank_count += int'(pt.blank_frame);
    stat_irq_count += int'(pt.stat_irq);
    vblank_count += int'(pt.vblank_irq);
  endtask

  // hold the sender until every expected beat is back, then let the pipe settle
  task automatic drain_results();
    in_valid <= 1'b0;
    burst_left = 0;
    while (pending_points.size() != 0) @(posedge clk);
    repeat (TAIL_WAIT) @(posedge clk);
  endtask

  // apb write of frame_skip followed by a read back
  task automatic write_frame_skip(logic [7:0] v);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= ADDR_W'(4 * int'(REG_FRAME_SKIP));
    pwdata  <= DATA_W'(v);
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    skip_cfg = v;
    skip_writes++;
    pwrite  <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata !== DATA_W'(v)) begin
      $display("%0t ns: frame_skip read back, expected %0d, got %0d", $time, v, prdata);
      err_count++;
    end
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // receiver: stall regimes that change every so often
  // ---------------------------------------------------------------------------
  int unsigned stall_left = 0;
  logic [1:0]  stall_kind = '0;

  always @(posedge clk) begin
    if (stall_left == 0) begin
      stall_kind <= 2'($urandom_range(0, 3));
      stall_left <= $urandom_range(16, 200);
    end else begin
      stall_left <= stall_left - 1;
    end
    case (stall_kind)
      2'd0: out_stall <= 1'b0;                          // free flowing
      2'd1: out_stall <= ($urandom_range(0, 7) == 0);   // light
      2'd2: out_stall <= ($urandom_range(0, 3) != 0);   // heavy
      default: out_stall <= stall_left[1];              // follows bit 1 of the countdown
    endcase
  end

  // ---------------------------------------------------------------------------
  // result checker: every accepted beat against the oldest expectation
  // ---------------------------------------------------------------------------
  function automatic void check_field(string name, logic [15:0] want, logic [15:0] got);
    if (got !== want) begin
      $display("%0t ns: %s mismatch, expected %0d, got %0d", $time, name, want, got);
      err_count++;
    end
  endfunction

  lsts_result_t want_pt;

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (pending_points.size() == 0) begin
        $display("%0t ns: unexpected result beat, expected none, got ly %0d", $time, out_ly);
        err_count++;
      end else begin
        want_pt = pending_points.pop_front();
        check_field("ly", 16'(want_pt.ly), 16'(out_ly));
        check_field("stat_mode", 16'(want_pt.stat_mode), 16'(out_stat_mode));
        check_field("coincidence", 16'(want_pt.coincidence), 16'(out_coincidence));
        check_field("stat_irq", 16'(want_pt.stat_irq), 16'(out_stat_irq));
        check_field("vblank_irq", 16'(want_pt.vblank_irq), 16'(out_vblank_irq));
        check_field("run_cycles", 16'(want_pt.run_cycles), 16'(out_run_cycles));
        check_field("frame_start", 16'(want_pt.frame_start), 16'(out_frame_start));
        check_field("frame_shown", 16'(want_pt.frame_shown), 16'(out_frame_shown));
        check_field("render_line", 16'(want_pt.render_line), 16'(out_render_line));
        check_field("blank_frame", 16'(want_pt.blank_frame), 16'(out_blank_frame));
        check_field("lcd_on", 16'(want_pt.lcd_on), 16'(out_lcd_on));
      end
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus
  // ---------------------------------------------------------------------------
  typedef struct {
    item_t        kind;
    logic [7:0]   val;
    bit           typed;
    lsts_result_t want;
  } dir_row_t;

  dir_row_t dir_rows [N_DIR];

  initial begin
    int unsigned phase_no, seg_len, pick, n_seg;
    logic [7:0]  rv;

    // directed rows; typed results only where they follow at a glance
    dir_rows = '{
      // writes straight after reset: line 153 still shown, all pulses low
      '{ITEM_LYC,  8'h00, 1'b1, typed_pt(8'd153, MODE_HBLANK, 1'b0, 1'b0, 1'b0, 9'd0,
                                         1'b0, 1'b0, 1'b0, 1'b0, 1'b1)},
      '{ITEM_STAT, 8'hFF, 1'b1, typed_pt(8'd153, MODE_HBLANK, 1'b0, 1'b0, 1'b0, 9'd0,
                                         1'b0, 1'b0, 1'b0, 1'b0, 1'b1)},
      // first tick: frame start on line 0, compare hits, hblank source edges
      '{ITEM_TICK, 8'h00, 1'b1, typed_pt(8'd0, MODE_OAM, 1'b1, 1'b1, 1'b0, RUN_OAM,
                                         1'b1, 1'b1, 1'b0, 1'b0, 1'b1)},
      '{ITEM_TICK, 8'hFF, 1'b0, NO_PT},   // value ignored on ticks
      '{ITEM_TICK, 8'h00, 1'b0, NO_PT},   // hblank point, line drawn
      '{ITEM_STAT, 8'h00, 1'b0, NO_PT},
      '{ITEM_LYC,  8'hFF, 1'b0, NO_PT},
      '{ITEM_STAT, 8'h40, 1'b0, NO_PT},   // compare source only
      '{ITEM_LYC,  8'h01, 1'b0, NO_PT},
      '{ITEM_TICK, 8'h00, 1'b0, NO_PT},   // line 1 start, compare hit
      '{ITEM_LCDC, 8'h7F, 1'b0, NO_PT},   // lcd off, other bits set
      // lcd off tick: ly 0, full line of cycles, compare flag frozen at 1
      '{ITEM_TICK, 8'h00, 1'b1, typed_pt(8'd0, MODE_HBLANK, 1'b1, 1'b0, 1'b0, RUN_LINE,
                                         1'b0, 1'b0, 1'b0, 1'b0, 1'b0)},
      '{ITEM_TICK, 8'h55, 1'b0, NO_PT},
      '{ITEM_LCDC, 8'h80, 1'b0, NO_PT},   // back on
      '{ITEM_STAT, 8'h78, 1'b0, NO_PT},   // every stat source
      '{ITEM_LYC,  8'h02, 1'b0, NO_PT},
      '{ITEM_TICK, 8'hAA, 1'b0, NO_PT},   // restart on the line after the counter
      '{ITEM_TICK, 8'h00, 1'b0, NO_PT},
      '{ITEM_TICK, 8'h00, 1'b0, NO_PT},
      '{ITEM_TICK, 8'h00, 1'b0, NO_PT},
      '{ITEM_TICK, 8'h00, 1'b0, NO_PT},
      '{ITEM_TICK, 8'h00, 1'b0, NO_PT},
      '{ITEM_LCDC, 8'hFF, 1'b0, NO_PT},
      '{ITEM_TICK, 8'h00, 1'b0, NO_PT}
    };

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (dir_rows[i])
      send_beat(dir_rows[i].kind, dir_rows[i].val, dir_rows[i].typed, dir_rows[i].want);

    // random phases, each under its own frame_skip setting
    phase_no = 0;
    while (beat_count < N_DIR + RAND_BEATS) begin
      drain_results();
      case (phase_no % 6)
        0: write_frame_skip(8'hFF);
        1: write_frame_skip(8'h00);
        2: write_frame_skip(8'h01);
        3: write_frame_skip(8'h02);
        4: write_frame_skip(8'h03);
        default: write_frame_skip(8'($urandom_range(0, 255)));
      endcase
      phase_no++;
      n_seg = $urandom_range(1, 3);
      repeat (n_seg) begin
        if (beat_count >= N_DIR + RAND_BEATS) break;
        if ($urandom_range(0, 3) == 0) begin
          // lcd off stretch: long enough for a blank frame most of the time
          rv = 8'($urandom_range(0, 127));
          send_beat(ITEM_LCDC, rv, 1'b0, NO_PT);
          seg_len = $urandom_range(100, 340);
          repeat (seg_len) begin
            if (beat_count >= N_DIR + RAND_BEATS) break;
            pick = $urandom_range(0, 99);
            rv = 8'($urandom_range(0, 255));
            if (pick < 95) send_beat(ITEM_TICK, rv, 1'b0, NO_PT);
            else if (pick < 98) send_beat(ITEM_STAT, rv, 1'b0, NO_PT);
            else send_beat(ITEM_LYC, rv, 1'b0, NO_PT);
          end
          rv = 8'($urandom_range(128, 255));
          send_beat(ITEM_LCDC, rv, 1'b0, NO_PT);
        end else begin
          // lcd on stretch: mostly ticks, writes mixed in
          if (!lcd_en) send_beat(ITEM_LCDC, 8'($urandom_range(128, 255)), 1'b0, NO_PT);
          seg_len = $urandom_range(60, 600);
          repeat (seg_len) begin
            if (beat_count >= N_DIR + RAND_BEATS) break;
            pick = $urandom_range(0, 99);
            rv = 8'($urandom_range(0, 255));
            if (lcd_en && line_no == LPF - 1 && next_point == 0 && pick < 50) begin
              // write while the last line already reads as 0
              send_beat(ITEM_LYC, 8'($urandom_range(0, LPF - 1)), 1'b0, NO_PT);
            end else if (pick < 88) begin
              send_beat(ITEM_TICK, rv, 1'b0, NO_PT);
            end else if (pick < 93) begin
              send_beat(ITEM_STAT, rv, 1'b0, NO_PT);
            end else if (pick < 98) begin
              if (pick < 96) rv = 8'($urandom_range(0, LPF - 1));
              send_beat(ITEM_LYC, rv, 1'b0, NO_PT);
            end else begin
              // occasional noise: may switch the lcd off mid frame
              send_beat(ITEM_LCDC, rv, 1'b0, NO_PT);
            end
          end
        end
      end
    end

    drain_results();
    if (pending_points.size() != 0) err_count++;

    $display("covered %0d beats: %0d ticks, %0d register writes, %0d frame_skip settings",
             beat_count, tick_count, write_count, skip_writes);
    $display("saw %0d frame starts (%0d shown, %0d blank), %0d stat and %0d vblank irqs",
             frame_count, shown_count, blank_count, stat_irq_count, vblank_count);
    if (err_count == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  // watchdog far beyond the slowest legal run
  initial begin
    #5_000_000;
    $display("FAILED: results differ");
    $finish;
  end

endmodule
